[rtl/mrb_pkg.sv]
// mailbox ring buffer package: operation and status codes, field widths
// no dependencies
`default_nettype none

package mrb_pkg;

  localparam int unsigned CapW  = 5;
  localparam int unsigned MsgW  = 32;
  localparam int unsigned FillW = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [1:0] {
    FUNC_GET        = 2'd0,
    FUNC_PUT_BACK   = 2'd1,
    FUNC_PUT_FRONT  = 2'd2,
    FUNC_FLUSH      = 2'd3
  } mrb_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mrb_status_e;

  typedef struct packed {
    logic we;
    logic re;
  } mrb_mem_ctl_t;

endpackage

`default_nettype wire

[rtl/mrb_slots.sv]
// message slot memory: one write port, one read port with registered data
// depends on mrb_pkg
`default_nettype none

module mrb_slots
  import mrb_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic            clk_i,
  input  mrb_mem_ctl_t    ctl_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [MsgW-1:0] wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [MsgW-1:0] rdata_o
);

  logic [MsgW-1:0] mem_q [DEPTH];
  logic [MsgW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/mailbox_ring_buffer_top.sv]
// mailbox ring buffer top level: pointer and count control, result register
// depends on mrb_pkg and mrb_slots
// the result strobe rises in the cycle after the item is accepted
// throughput: one item per cycle, busy is never raised, the receiver cannot stall
// reset: pointers and count cleared, capacity set to 16; slot memory is not cleared
`default_nettype none

module mailbox_ring_buffer_top
  import mrb_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       func_i,
  input  logic [MsgW-1:0]  message_i,
  input  logic             cfg_we_i,
  input  logic [CapW-1:0]  cfg_wdata_i,
  output logic             out_strobe_o,
  output logic [1:0]       status_o,
  output logic [MsgW-1:0]  message_out_o,
  output logic [FillW-1:0] fill_level_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW = (AW + 1 > CapW + 1) ? AW + 1 : CapW + 1;
  localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);

  logic [CapW-1:0]  cap_q;
  logic [AW-1:0]    rp_q, rp_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [FillW-1:0] held_q, held_d;

  logic             strobe_q;
  mrb_status_e      status_q, status_d;
  logic             got_q;
  logic [FillW-1:0] fill_q;

  logic             accept;
  mrb_func_e        func;
  logic [CmpW-1:0]  cap_min, eff_cap, rp_inc, wp_inc, held_ext;
  logic [AW-1:0]    rp_next, wp_next, rp_prev;
  logic             full, empty;
  mrb_mem_ctl_t     mem_ctl;
  logic [AW-1:0]    waddr;
  logic [MsgW-1:0]  rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign func   = mrb_func_e'(func_i);

  // effective capacity, clamped to 1..DEPTH
  assign cap_min = (cap_q == '0) ? CmpW'(1) : CmpW'(cap_q);
  assign eff_cap = (cap_min > DepthC) ? DepthC : cap_min;

  assign rp_inc  = CmpW'(rp_q) + CmpW'(1);
  assign wp_inc  = CmpW'(wp_q) + CmpW'(1);
  assign rp_next = (rp_inc >= eff_cap) ? '0 : rp_inc[AW-1:0];
  assign wp_next = (wp_inc >= eff_cap) ? '0 : wp_inc[AW-1:0];
  assign rp_prev = (rp_q == '0) ? AW'(eff_cap - CmpW'(1)) : rp_q - AW'(1);

  assign held_ext = CmpW'(held_q);
  assign full     = held_ext >= eff_cap;
  assign empty    = held_q == '0;

  always_comb begin
    rp_d       = rp_q;
    wp_d       = wp_q;
    held_d     = held_q;
    status_d   = ST_OK;
    mem_ctl    = '0;
    waddr      = wp_q;
    unique case (func)
      FUNC_GET: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          mem_ctl.re = accept;
          rp_d       = rp_next;
          held_d     = held_q - FillW'(1);
        end
      end
      FUNC_PUT_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          mem_ctl.we = accept;
          wp_d       = wp_next;
          held_d     = held_q + FillW'(1);
        end
      end
      FUNC_PUT_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          mem_ctl.we = accept;
          waddr      = rp_prev;
          rp_d       = rp_prev;
          held_d     = held_q + FillW'(1);
        end
      end
      FUNC_FLUSH: begin
        rp_d   = '0;
        wp_d   = '0;
        held_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  mrb_slots #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_slots (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (message_i),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CapReset;
      rp_q     <= '0;
      wp_q     <= '0;
      held_q   <= '0;
      strobe_q <= 1'b0;
      got_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      strobe_q <= accept;
      got_q    <= mem_ctl.re;
      if (accept) begin
        rp_q   <= rp_d;
        wp_q   <= wp_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      fill_q   <= held_d;
    end
  end

  assign out_strobe_o  = strobe_q;
  assign status_o      = status_q;
  assign message_out_o = got_q ? rdata : '0;
  assign fill_level_o  = fill_q;

  // one result per accepted item, in the next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_strobe_o)
    else $error("result strobe missing after accepted item");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !out_strobe_o)
    else $error("result strobe without accepted item");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(held_q) <= DepthC)
    else $error("message count above depth");

  a_full_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && status_o == ST_FULL) |-> (fill_level_o != '0))
    else $error("full reported with nothing held");

  a_msg_only_on_get : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && status_o != ST_OK) |-> (message_out_o == '0))
    else $error("message returned on failed operation");

endmodule

`default_nettype wire

[test/testbench.sv]
// testbench for mailbox_ring_buffer_top: directed and random get, put and flush items
// checked against a predictor of the ring buffer; depends on mrb_pkg and the block's rtl
`timescale 1ns / 1ps

module testbench;
  import mrb_pkg::*;

  localparam int unsigned Slots = 16;
  localparam int unsigned PhaseItems = 104;
  localparam int unsigned Phases = 12;
  localparam int unsigned QuietLimit = 1000;

  typedef struct packed {
    mrb_status_e      status;
    logic [MsgW-1:0]  msg;
    logic [FillW-1:0] fill;
  } outcome_t;

  class mailbox_scoreboard;
    logic [MsgW-1:0]  slot_words [Slots];
    bit               written [Slots];
    logic [3:0]       rd_idx;
    logic [3:0]       wr_idx;
    logic [FillW-1:0] held_cnt;
    logic [CapW-1:0]  cap_reg;
    outcome_t         pending_outcomes [$];
    int unsigned      fail_count;

    function new();
      foreach (written[i]) begin
        written[i] = 1'b0;
        slot_words[i] = '0;
      end
      rd_idx = '0;
      wr_idx = '0;
      held_cnt = '0;
      cap_reg = CapReset;
      fail_count = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] v);
      cap_reg = v;
    endfunction

    function logic [4:0] usable_slots();
      if (cap_reg == 0) return 5'd1;
      if (cap_reg > Slots) return 5'(Slots);
      return cap_reg;
    endfunction

    function logic [3:0] step_fwd(logic [3:0] p, logic [4:0] cap);
      logic [4:0] n;
      n = {1'b0, p} + 5'd1;
      return (n >= cap) ? 4'd0 : n[3:0];
    endfunction

    // a get would land on a slot never written since reset
    function bit front_unwritten();
      return (held_cnt != 0) && !written[rd_idx];
    endfunction

    function void note_operation(mrb_func_e f, logic [MsgW-1:0] m);
      outcome_t o;
      logic [4:0] cap;
      cap = usable_slots();
      o.status = ST_OK;
      o.msg = '0;
      case (f)
        FUNC_GET: begin
          if (held_cnt != 0) begin
            held_cnt = held_cnt - FillW'(1);
            o.msg = slot_words[rd_idx];
            rd_idx = step_fwd(rd_idx, cap);
          end else begin
            o.status = ST_EMPTY;
          end
        end
        FUNC_PUT_BACK, FUNC_PUT_FRONT: begin
          if (held_cnt >= cap) begin
            o.status = ST_FULL;
          end else if (f == FUNC_PUT_FRONT) begin
            rd_idx = (rd_idx == 0) ? 4'(cap - 5'd1) : rd_idx - 4'd1;
            slot_words[rd_idx] = m;
            written[rd_idx] = 1'b1;
            held_cnt = held_cnt + FillW'(1);
          end else begin
            slot_words[wr_idx] = m;
            written[wr_idx] = 1'b1;
            wr_idx = step_fwd(wr_idx, cap);
            held_cnt = held_cnt + FillW'(1);
          end
        end
        default: begin
          rd_idx = '0;
          wr_idx = '0;
          held_cnt = '0;
        end
      endcase
      o.fill = held_cnt;
      pending_outcomes.push_back(o);
    endfunction

    function void check_outcome(logic [1:0] st, logic [MsgW-1:0] m, logic [FillW-1:0] fill);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with no item pending: status %0d message %h fill %0d",
                 $time, st, m, fill);
        fail_count++;
        return;
      end
      o = pending_outcomes.pop_front();
      if (st !== o.status) begin
        $display("%0t: status expected %0d actual %0d", $time, o.status, st);
        fail_count++;
      end
      if (m !== o.msg) begin
        $display("%0t: message expected %h actual %h", $time, o.msg, m);
        fail_count++;
      end
      if (fill !== o.fill) begin
        $display("%0t: fill level expected %0d actual %0d", $time, o.fill, fill);
        fail_count++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       func_i = FUNC_GET;
  logic [MsgW-1:0]  message_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [CapW-1:0]  cfg_wdata_i = '0;
  logic             out_strobe_o;
  logic [1:0]       status_o;
  logic [MsgW-1:0]  message_out_o;
  logic [FillW-1:0] fill_level_o;

  mailbox_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  mailbox_ring_buffer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .message_i    (message_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_strobe_o (out_strobe_o),
    .status_o     (status_o),
    .message_out_o(message_out_o),
    .fill_level_o (fill_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) sb.check_outcome(status_o, message_out_o, fill_level_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || out_strobe_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  function automatic logic [MsgW-1:0] random_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_op(input mrb_func_e f, input logic [MsgW-1:0] m);
    start <= 1'b1;
    func_i <= f;
    message_i <= m;
    do @(posedge clk_i); while (busy);
    sb.note_operation(f, m);
    items_sent++;
  endtask

  task automatic issue_get();
    if (sb.front_unwritten()) issue_op(FUNC_FLUSH, random_word());
    else issue_op(FUNC_GET, random_word());
  endtask

  task automatic idle_gap(input int unsigned n);
    start <= 1'b0;
    func_i <= 2'($urandom_range(0, 3));
    message_i <= $urandom;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_gap(input bit no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return;
    if (r < 90) idle_gap($urandom_range(1, 3));
    else if (r < 98) idle_gap($urandom_range(4, 10));
    else idle_gap($urandom_range(20, 60));
  endtask

  // no result outstanding, then a margin for the registered result
  task automatic settle();
    start <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_capacity(v);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= CapW'($urandom);
  endtask

  task automatic random_put(input bit no_idle);
    if ($urandom_range(0, 2) == 0) issue_op(FUNC_PUT_FRONT, random_word());
    else issue_op(FUNC_PUT_BACK, random_word());
    maybe_gap(no_idle);
  endtask

  task automatic run_phase(input logic [CapW-1:0] cap, input int unsigned target);
    bit no_idle;
    int unsigned pick;
    int unsigned len;
    if ($urandom_range(0, 1)) issue_op(FUNC_FLUSH, random_word());
    write_capacity(cap);
    no_idle = ($urandom_range(0, 3) == 0);
    while (items_sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        len = $urandom_range(1, sb.usable_slots() + 2);
        repeat (len) random_put(no_idle);
      end else if (pick < 15) begin
        len = $urandom_range(1, sb.held_cnt + 2);
        repeat (len) begin
          issue_get();
          maybe_gap(no_idle);
        end
      end else if (pick < 19) begin
        case ($urandom_range(0, 7))
          0: issue_op(FUNC_FLUSH, random_word());
          1, 2, 3: issue_get();
          default: random_put(1'b1);
        endcase
        maybe_gap(no_idle);
      end else begin
        issue_op(FUNC_FLUSH, random_word());
        maybe_gap(no_idle);
      end
    end
  endtask

  initial begin
    logic [CapW-1:0] edge_caps [5];
    logic [CapW-1:0] cap;
    edge_caps = '{5'd31, 5'd17, 5'd16, 5'd1, 5'd0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity, put-front wrapping below slot zero
    issue_get();
    issue_op(FUNC_PUT_BACK, 32'h0000_0000);
    issue_op(FUNC_PUT_BACK, 32'hFFFF_FFFF);
    issue_op(FUNC_PUT_FRONT, 32'h8000_0001);
    issue_get();
    issue_get();
    idle_gap(2);
    issue_get();
    issue_get();
    issue_op(FUNC_PUT_FRONT, 32'h1234_5678);
    issue_op(FUNC_FLUSH, 32'hFFFF_FFFF);
    issue_get();

    write_capacity(5'd1);
    issue_op(FUNC_PUT_BACK, 32'hA5A5_A5A5);
    issue_op(FUNC_PUT_BACK, 32'h0F0F_0F0F);
    issue_op(FUNC_PUT_FRONT, 32'hF0F0_F0F0);
    issue_get();
    issue_op(FUNC_PUT_FRONT, 32'h5A5A_5A5A);
    issue_get();

    // zero acts as one
    write_capacity(5'd0);
    issue_op(FUNC_PUT_FRONT, 32'h0000_0001);
    issue_op(FUNC_PUT_BACK, 32'h0000_0002);
    issue_get();

    // shrink while messages are held
    write_capacity(5'd4);
    issue_op(FUNC_PUT_BACK, 32'hDEAD_BEEF);
    issue_op(FUNC_PUT_BACK, 32'hCAFE_F00D);
    issue_op(FUNC_PUT_BACK, 32'h7FFF_FFFF);
    write_capacity(5'd2);
    issue_op(FUNC_PUT_FRONT, 32'h1111_1111);
    repeat (4) issue_get();

    for (int unsigned p = 0; p < Phases; p++) begin
      if (p < 5) cap = edge_caps[p];
      else if ($urandom_range(0, 3) == 0) cap = CapW'($urandom_range(0, 31));
      else cap = CapW'($urandom_range(1, 5));
      run_phase(cap, items_sent + PhaseItems);
    end

    settle();
    if (sb.fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
